// File: rtl/shell_command_lexer_top_defines.svh
// ----------------------------------------------------------------------------
// shell command lexer assertion macros
// shared check forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LEXER_TOP_DEFINES_SVH
`define SHELL_COMMAND_LEXER_TOP_DEFINES_SVH

// condition holds at every edge
`define SCL_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("scl: invariant violated");

// same-cycle implication
`define SCL_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scl: implication violated");

// next-cycle implication
`define SCL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scl: next-cycle check violated");

`endif

// File: rtl/scl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// shared types, constants and character classes of the shell command lexer
// ----------------------------------------------------------------------------
package scl_pkg;

	localparam int MAX_SYMBOL = 32;
	localparam int CNT_W      = $clog2(MAX_SYMBOL + 1);
	localparam int ADDR_W     = $clog2(MAX_SYMBOL);
	localparam int KW_NUM     = 8;
	localparam int KW_MAX     = 5;
	localparam int KW_IDX_W   = $clog2(KW_MAX);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_BQ   = 8'h60;
	localparam logic [7:0] CH_PIPE = 8'h7C;

	typedef enum logic [3:0] {
		K_SYMBOL  = 4'd0,
		K_KEYWORD = 4'd1,
		K_NEWLINE = 4'd2,
		K_PIPE    = 4'd3,
		K_OR      = 4'd4,
		K_AMP     = 4'd5,
		K_AND     = 4'd6,
		K_SEMI    = 4'd7,
		K_WRITE   = 4'd8,
		K_END     = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_PIPE,
		M_AMP,
		M_SYMBOL,
		M_QUOTE,
		M_COMMENT,
		M_STOPPED
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_STORE,
		OP_TOKEN,
		OP_PAIR,
		OP_FLUSH,
		OP_END
	} op_code_t;

	typedef struct packed {
		op_code_t   code;
		kind_t      kind;
		logic [7:0] ch;
		logic       run_last;
		logic       stop;
	} op_t;

	typedef struct packed {
		op_t        op;
		mode_t      mode;
		logic [7:0] quote;
	} idle_t;

	localparam logic [KW_MAX-1:0][7:0] KW_TEXT [KW_NUM] = '{
		{8'd0, 8'd0, 8'd0, "f", "i"},
		{8'd0, 8'd0, 8'd0, "i", "f"},
		{8'd0, "n", "e", "h", "t"},
		{"e", "l", "i", "h", "w"},
		{8'd0, 8'd0, 8'd0, "o", "d"},
		{8'd0, "e", "n", "o", "d"},
		{8'd0, "e", "s", "l", "e"},
		{8'd0, "f", "i", "l", "e"}
	};

	localparam logic [CNT_W-1:0] KW_LEN [KW_NUM] = '{
		CNT_W'(2), CNT_W'(2), CNT_W'(4), CNT_W'(5),
		CNT_W'(2), CNT_W'(4), CNT_W'(4), CNT_W'(4)
	};

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_sym_char(input logic [7:0] b);
		return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h2F, 8'h5F, 8'h2D, 8'h2E, 8'h3A, 8'h3D,
			CH_DQ, 8'h24, CH_BQ, CH_SQ, 8'h2B, 8'h2A};
	endfunction

	function automatic op_t mk_op(input op_code_t code, input kind_t kind,
			input logic [7:0] ch);
		op_t o;
		o.code     = code;
		o.kind     = kind;
		o.ch       = ch;
		o.run_last = 1'b1;
		o.stop     = 1'b0;
		return o;
	endfunction

	// action of a byte seen between tokens
	function automatic idle_t idle_byte(input logic [7:0] b);
		idle_t r;
		r.op    = mk_op(OP_NONE, K_SYMBOL, CH_NUL);
		r.mode  = M_IDLE;
		r.quote = CH_NUL;
		if (is_space(b)) begin
			if (b == CH_NL) begin
				r.op = mk_op(OP_TOKEN, K_NEWLINE, CH_NL);
			end
		end else if (b == CH_PIPE) begin
			r.mode = M_PIPE;
		end else if (b == CH_AMP) begin
			r.mode = M_AMP;
		end else if (b == CH_SEMI) begin
			r.op = mk_op(OP_TOKEN, K_SEMI, CH_SEMI);
		end else if (b == CH_GT) begin
			r.op = mk_op(OP_TOKEN, K_WRITE, CH_GT);
		end else if (b == CH_HASH) begin
			r.op   = mk_op(OP_TOKEN, K_NEWLINE, CH_NL);
			r.mode = M_COMMENT;
		end else if (b == CH_DQ) begin
			r.mode  = M_QUOTE;
			r.quote = b;
		end else if (b == CH_SQ || b == CH_BQ) begin
			r.op    = mk_op(OP_STORE, K_SYMBOL, b);
			r.mode  = M_QUOTE;
			r.quote = b;
		end else if (is_sym_char(b)) begin
			r.op   = mk_op(OP_STORE, K_SYMBOL, b);
			r.mode = M_SYMBOL;
		end else begin
			r.mode = M_STOPPED;
		end
		return r;
	endfunction

	function automatic logic kw_hit(input logic [CNT_W-1:0] cnt,
			input logic [KW_MAX-1:0][7:0] pre);
		logic hit;
		logic ok;
		hit = 1'b0;
		for (int k = 0; k < KW_NUM; k++) begin
			ok = (cnt == KW_LEN[k]);
			for (int j = 0; j < KW_MAX; j++) begin
				if (CNT_W'(j) < KW_LEN[k] && pre[j] != KW_TEXT[k][j]) begin
					ok = 1'b0;
				end
			end
			hit = hit | ok;
		end
		return hit;
	endfunction

	function automatic logic makes_result(input op_code_t code);
		return code inside {OP_TOKEN, OP_PAIR, OP_FLUSH, OP_END};
	endfunction

endpackage

// File: rtl/scl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_front
// accepts text words, tracks lexer mode and quote, issues back-end commands
// ----------------------------------------------------------------------------
module scl_front import scl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       push,
	output op_t        push_op,
	input  logic       fifo_full
);

	mode_t      mode_q, mode_nxt;
	logic [7:0] quote_q, quote_nxt;
	logic       hold_valid_q;
	op_t        hold_op_q;
	op_t        op0, op1;
	idle_t      idl;
	logic       accept;

	assign text_stall = hold_valid_q | fifo_full;
	assign accept     = text_valid & ~text_stall;

	always_comb begin
		idl       = idle_byte(text_byte);
		op0       = mk_op(OP_NONE, K_SYMBOL, CH_NUL);
		op1       = mk_op(OP_NONE, K_SYMBOL, CH_NUL);
		mode_nxt  = mode_q;
		quote_nxt = quote_q;
		if (end_of_text) begin
			case (mode_q)
				M_PIPE: begin
					op0 = mk_op(OP_TOKEN, K_PIPE, CH_PIPE);
					op1 = mk_op(OP_END, K_END, CH_NUL);
				end
				M_AMP: begin
					op0 = mk_op(OP_TOKEN, K_AMP, CH_AMP);
					op1 = mk_op(OP_END, K_END, CH_NUL);
				end
				M_SYMBOL, M_QUOTE: begin
					op0 = mk_op(OP_FLUSH, K_SYMBOL, CH_NUL);
					op1 = mk_op(OP_END, K_END, CH_NUL);
				end
				default: begin
					op0      = mk_op(OP_END, K_END, CH_NUL);
					op0.stop = (mode_q == M_STOPPED);
				end
			endcase
			mode_nxt  = M_IDLE;
			quote_nxt = CH_NUL;
		end else begin
			case (mode_q)
				M_PIPE, M_AMP: begin
					if (mode_q == M_PIPE && text_byte == CH_PIPE) begin
						op0      = mk_op(OP_PAIR, K_OR, CH_PIPE);
						mode_nxt = M_IDLE;
					end else if (mode_q == M_AMP && text_byte == CH_AMP) begin
						op0      = mk_op(OP_PAIR, K_AND, CH_AMP);
						mode_nxt = M_IDLE;
					end else begin
						op0 = (mode_q == M_PIPE) ? mk_op(OP_TOKEN, K_PIPE, CH_PIPE)
							: mk_op(OP_TOKEN, K_AMP, CH_AMP);
						op1       = idl.op;
						mode_nxt  = idl.mode;
						quote_nxt = idl.quote;
					end
				end
				M_SYMBOL: begin
					if (text_byte == CH_DQ) begin
						mode_nxt  = M_QUOTE;
						quote_nxt = text_byte;
					end else if (text_byte == CH_SQ || text_byte == CH_BQ) begin
						op0       = mk_op(OP_STORE, K_SYMBOL, text_byte);
						mode_nxt  = M_QUOTE;
						quote_nxt = text_byte;
					end else if (is_sym_char(text_byte)) begin
						op0 = mk_op(OP_STORE, K_SYMBOL, text_byte);
					end else begin
						op0       = mk_op(OP_FLUSH, K_SYMBOL, CH_NUL);
						op1       = idl.op;
						mode_nxt  = idl.mode;
						quote_nxt = idl.quote;
					end
				end
				M_QUOTE: begin
					if (text_byte == quote_q) begin
						if (text_byte != CH_DQ) begin
							op0 = mk_op(OP_STORE, K_SYMBOL, text_byte);
						end
						quote_nxt = CH_NUL;
						mode_nxt  = M_SYMBOL;
					end else begin
						op0 = mk_op(OP_STORE, K_SYMBOL, text_byte);
					end
				end
				M_COMMENT: begin
					if (text_byte == CH_NL || text_byte == CH_NUL) begin
						op0       = idl.op;
						mode_nxt  = idl.mode;
						quote_nxt = idl.quote;
					end
				end
				M_STOPPED: begin
					mode_nxt = M_STOPPED;
				end
				default: begin
					op0       = idl.op;
					mode_nxt  = idl.mode;
					quote_nxt = idl.quote;
				end
			endcase
		end
		op0.run_last = ~makes_result(op1.code);
		op1.run_last = 1'b1;
	end

	assign push    = ~fifo_full & (hold_valid_q | (accept & (op0.code != OP_NONE)));
	assign push_op = hold_valid_q ? hold_op_q : op0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			quote_q      <= CH_NUL;
			hold_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q       <= mode_nxt;
				quote_q      <= quote_nxt;
				hold_valid_q <= (op1.code != OP_NONE);
			end else if (hold_valid_q && !fifo_full) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_op_q <= op1;
		end
	end

endmodule

// File: rtl/scl_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_fifo
// short command queue between the front and back of the lexer
// ----------------------------------------------------------------------------
module scl_fifo import scl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head_op,
	output logic head_valid
);

	op_t                   entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fill_q;
	logic                  do_pop;

	assign full       = (fill_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_op    = entries_q[rd_ptr_q];
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + FIFO_CNT_W'(1);
			end else if (do_pop && !push) begin
				fill_q <= fill_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// File: rtl/scl_back.sv
`timescale 1ns / 1ps
`include "shell_command_lexer_top_defines.svh"
// ----------------------------------------------------------------------------
// scl_back
// runs queued commands: buffers symbol text and, while token_stall is low,
// replays tokens into the output register one word per cycle
// ----------------------------------------------------------------------------
module scl_back import scl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        head_op,
	input  logic       head_valid,
	output logic       pop,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [3:0] token_kind,
	output logic [7:0] token_char,
	output logic       char_valid,
	output logic       token_last,
	output logic       run_last,
	output logic       symbol_truncated,
	output logic       stopped_early
);

	logic [7:0]             mem [MAX_SYMBOL];
	logic [7:0]             rd_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q, idx_nxt;
	logic                   ovf_q;
	logic [KW_MAX-1:0][7:0] pre_q;

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] char_q;
	logic       cvalid_q, tlast_q, rlast_q, trunc_q, stop_q, from_mem_q;

	logic       out_free, emit, use_mem, do_store, clear_sym, flush_last;
	kind_t      r_kind, flush_kind;
	logic [7:0] r_char;
	logic       r_cvalid, r_tlast, r_rlast, r_trunc, r_stop;

	assign out_free   = ~out_valid_q | ~token_stall;
	assign flush_kind = (!ovf_q && kw_hit(count_q, pre_q)) ? K_KEYWORD : K_SYMBOL;
	assign flush_last = (count_q == '0) || (idx_q == count_q - CNT_W'(1));

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		use_mem   = 1'b0;
		do_store  = 1'b0;
		clear_sym = 1'b0;
		idx_nxt   = idx_q;
		r_kind    = head_op.kind;
		r_char    = head_op.ch;
		r_cvalid  = 1'b1;
		r_tlast   = 1'b1;
		r_rlast   = head_op.run_last;
		r_trunc   = 1'b0;
		r_stop    = 1'b0;
		if (head_valid) begin
			case (head_op.code)
				OP_STORE: begin
					do_store = 1'b1;
					pop      = 1'b1;
				end
				OP_TOKEN: begin
					emit = out_free;
					pop  = out_free;
				end
				OP_END: begin
					emit      = out_free;
					pop       = out_free;
					clear_sym = out_free;
					r_cvalid  = 1'b0;
					r_stop    = head_op.stop;
				end
				OP_PAIR: begin
					emit    = out_free;
					pop     = out_free & idx_q[0];
					r_tlast = idx_q[0];
					r_rlast = head_op.run_last & idx_q[0];
					if (out_free) begin
						idx_nxt = idx_q[0] ? '0 : CNT_W'(1);
					end
				end
				OP_FLUSH: begin
					emit      = out_free;
					pop       = out_free & flush_last;
					clear_sym = out_free & flush_last;
					r_kind    = flush_kind;
					r_char    = CH_NUL;
					r_cvalid  = (count_q != '0);
					use_mem   = (count_q != '0);
					r_tlast   = flush_last;
					r_rlast   = head_op.run_last & flush_last;
					r_trunc   = ovf_q;
					if (out_free) begin
						idx_nxt = flush_last ? '0 : idx_q + CNT_W'(1);
					end
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_nxt;
			if (clear_sym) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (do_store) begin
				if (count_q < CNT_W'(MAX_SYMBOL)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!token_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// symbol text and keyword prefix
	always_ff @(posedge clk) begin
		if (do_store && count_q < CNT_W'(MAX_SYMBOL)) begin
			mem[count_q[ADDR_W-1:0]] <= head_op.ch;
		end
		if (do_store && count_q < CNT_W'(KW_MAX)) begin
			pre_q[count_q[KW_IDX_W-1:0]] <= head_op.ch;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && use_mem) begin
			rd_q <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q     <= r_kind;
			char_q     <= r_char;
			cvalid_q   <= r_cvalid;
			tlast_q    <= r_tlast;
			rlast_q    <= r_rlast;
			trunc_q    <= r_trunc;
			stop_q     <= r_stop;
			from_mem_q <= use_mem;
		end
	end

	assign token_valid      = out_valid_q;
	assign token_kind       = kind_q;
	assign token_char       = from_mem_q ? rd_q : char_q;
	assign char_valid       = cvalid_q;
	assign token_last       = tlast_q;
	assign run_last         = rlast_q;
	assign symbol_truncated = trunc_q;
	assign stopped_early    = stop_q;

	`SCL_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(MAX_SYMBOL))
	`SCL_ASSERT_IMPLY(a_ovf_full, ovf_q, count_q == CNT_W'(MAX_SYMBOL))
	`SCL_ASSERT_IMPLY(a_flush_idx, head_valid && head_op.code == OP_FLUSH, idx_q < count_q || idx_q == '0)
	`SCL_ASSERT_NEXT(a_end_clears, emit && head_op.code == OP_END, count_q == '0 && !ovf_q && idx_q == '0)

endmodule

// File: rtl/shell_command_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_lexer_top
// shell command lexer: text words in, one token character per output word
// ----------------------------------------------------------------------------
// text channel: text_valid / text_stall carry text_byte and end_of_text.
// token channel: token_valid / token_stall carry one token character per
// word with its kind, char_valid, token_last, run_last and flags.
// a word moves at an edge where valid is high and stall is low.
// the front takes one text word per cycle while text_stall is low and turns
// it into at most two commands; a word that needs two commands holds the
// input until the second command has been queued. commands wait in a
// four-entry queue for the back end. the back end buffers symbol text (up
// to 32 characters), one store command per character, and replays the
// symbol as one output word per cycle while token_stall is low; "||" and
// "&&" give two output words each, other tokens one.
// the first output word caused by a text word passes through the command
// queue and the output word register.
// a stalled token channel holds the output word; the queue then fills and
// text_stall rises. reset clears mode, queue and output valid; symbol
// buffer contents are never read before being written.
// ----------------------------------------------------------------------------
module shell_command_lexer_top import scl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [3:0] token_kind,
	output logic [7:0] token_char,
	output logic       char_valid,
	output logic       token_last,
	output logic       run_last,
	output logic       symbol_truncated,
	output logic       stopped_early
);

	logic push, fifo_full, pop, head_valid;
	op_t  push_op, head_op;

	scl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.push       (push),
		.push_op    (push_op),
		.fifo_full  (fifo_full)
	);

	scl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (fifo_full),
		.pop       (pop),
		.head_op   (head_op),
		.head_valid(head_valid)
	);

	scl_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_op         (head_op),
		.head_valid      (head_valid),
		.pop             (pop),
		.token_valid     (token_valid),
		.token_stall     (token_stall),
		.token_kind      (token_kind),
		.token_char      (token_char),
		.char_valid      (char_valid),
		.token_last      (token_last),
		.run_last        (run_last),
		.symbol_truncated(symbol_truncated),
		.stopped_early   (stopped_early)
	);

endmodule

// File: verif/shell_command_lexer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_lexer_checker
// watches the text and token channels of the shell command lexer, works out
// the token words that every accepted text word must cause and compares each
// accepted token word field by field with the oldest word still expected
// ----------------------------------------------------------------------------
module shell_command_lexer_checker import scl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	input  logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic       token_valid,
	input  logic       token_stall,
	input  logic [3:0] token_kind,
	input  logic [7:0] token_char,
	input  logic       char_valid,
	input  logic       token_last,
	input  logic       run_last,
	input  logic       symbol_truncated,
	input  logic       stopped_early,
	output int         fail_count,
	output int         pending_words
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       cv;
		logic       tlast;
		logic       rlast;
		logic       trunc;
		logic       stop;
	} token_word_t;

	string kw_list [8] = '{"if", "fi", "then", "while", "do", "done", "else", "elif"};

	mode_t       lex_mode;
	logic [7:0]  quote_ch;
	logic [7:0]  sym_buf [MAX_SYMBOL];
	int          sym_len;
	logic        sym_over;
	token_word_t step_words [$];
	token_word_t expected_words [$];

	initial begin
		fail_count    = 0;
		pending_words = 0;
	end

	function automatic bit spacing(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic bit word_char(input logic [7:0] b);
		if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
			return 1'b1;
		case (b)
			"/", "_", "-", ".", ":", "=", CH_DQ, "$", CH_BQ, CH_SQ, "+", "*": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void put_word(input kind_t k, input logic [7:0] c, input logic v,
			input logic l, input logic t, input logic s);
		token_word_t w;
		w.kind  = k;
		w.ch    = c;
		w.cv    = v;
		w.tlast = l;
		w.rlast = 1'b0;
		w.trunc = t;
		w.stop  = s;
		if (step_words.size() <= MAX_SYMBOL) begin
			step_words.push_back(w);
		end
	endfunction

	function automatic void reset_lexer();
		lex_mode = M_IDLE;
		quote_ch = CH_NUL;
		sym_len  = 0;
		sym_over = 1'b0;
	endfunction

	function automatic void keep_char(input logic [7:0] b);
		if (sym_len < MAX_SYMBOL) begin
			sym_buf[sym_len] = b;
			sym_len++;
		end else begin
			sym_over = 1'b1;
		end
	endfunction

	function automatic bit keyword_text();
		bit hit;
		bit same;
		hit = 1'b0;
		foreach (kw_list[k]) begin
			if (kw_list[k].len() == sym_len) begin
				same = 1'b1;
				for (int j = 0; j < sym_len; j++) begin
					if (sym_buf[j] != kw_list[k][j]) begin
						same = 1'b0;
					end
				end
				hit |= same;
			end
		end
		return hit;
	endfunction

	function automatic void flush_sym();
		kind_t k;
		k = K_SYMBOL;
		if (!sym_over && keyword_text()) begin
			k = K_KEYWORD;
		end
		if (sym_len == 0) begin
			put_word(k, CH_NUL, 1'b0, 1'b1, sym_over, 1'b0);
		end else begin
			for (int i = 0; i < sym_len; i++) begin
				put_word(k, sym_buf[i], 1'b1, i + 1 == sym_len, sym_over, 1'b0);
			end
		end
		reset_lexer();
	endfunction

	function automatic void sym_byte(input logic [7:0] b);
		if (b == CH_DQ) begin
			quote_ch = b;
			lex_mode = M_QUOTE;
		end else if (b == CH_SQ || b == CH_BQ) begin
			keep_char(b);
			quote_ch = b;
			lex_mode = M_QUOTE;
		end else if (word_char(b)) begin
			keep_char(b);
		end else begin
			flush_sym();
		end
	endfunction

	// byte seen between tokens
	function automatic void lead_byte(input logic [7:0] b);
		if (spacing(b)) begin
			if (b == CH_NL) begin
				put_word(K_NEWLINE, CH_NL, 1'b1, 1'b1, 1'b0, 1'b0);
			end
		end else if (b == CH_PIPE) begin
			lex_mode = M_PIPE;
		end else if (b == CH_AMP) begin
			lex_mode = M_AMP;
		end else if (b == CH_SEMI) begin
			put_word(K_SEMI, CH_SEMI, 1'b1, 1'b1, 1'b0, 1'b0);
		end else if (b == CH_GT) begin
			put_word(K_WRITE, CH_GT, 1'b1, 1'b1, 1'b0, 1'b0);
		end else if (b == CH_HASH) begin
			put_word(K_NEWLINE, CH_NL, 1'b1, 1'b1, 1'b0, 1'b0);
			lex_mode = M_COMMENT;
		end else if (word_char(b)) begin
			sym_len  = 0;
			sym_over = 1'b0;
			lex_mode = M_SYMBOL;
			sym_byte(b);
		end else begin
			lex_mode = M_STOPPED;
		end
	endfunction

	function automatic void predict(input logic [7:0] b, input logic e);
		bit halted;
		step_words.delete();
		if (e) begin
			halted = (lex_mode == M_STOPPED);
			case (lex_mode)
				M_PIPE: put_word(K_PIPE, CH_PIPE, 1'b1, 1'b1, 1'b0, 1'b0);
				M_AMP: put_word(K_AMP, CH_AMP, 1'b1, 1'b1, 1'b0, 1'b0);
				M_SYMBOL, M_QUOTE: flush_sym();
				default: ;
			endcase
			put_word(K_END, CH_NUL, 1'b0, 1'b1, 1'b0, halted);
			reset_lexer();
		end else begin
			case (lex_mode)
				M_PIPE: begin
					lex_mode = M_IDLE;
					if (b == CH_PIPE) begin
						put_word(K_OR, CH_PIPE, 1'b1, 1'b0, 1'b0, 1'b0);
						put_word(K_OR, CH_PIPE, 1'b1, 1'b1, 1'b0, 1'b0);
					end else begin
						put_word(K_PIPE, CH_PIPE, 1'b1, 1'b1, 1'b0, 1'b0);
						lead_byte(b);
					end
				end
				M_AMP: begin
					lex_mode = M_IDLE;
					if (b == CH_AMP) begin
						put_word(K_AND, CH_AMP, 1'b1, 1'b0, 1'b0, 1'b0);
						put_word(K_AND, CH_AMP, 1'b1, 1'b1, 1'b0, 1'b0);
					end else begin
						put_word(K_AMP, CH_AMP, 1'b1, 1'b1, 1'b0, 1'b0);
						lead_byte(b);
					end
				end
				M_SYMBOL: begin
					sym_byte(b);
					if (lex_mode == M_IDLE) begin
						lead_byte(b);
					end
				end
				M_QUOTE: begin
					if (b == quote_ch) begin
						if (b != CH_DQ) begin
							keep_char(b);
						end
						quote_ch = CH_NUL;
						lex_mode = M_SYMBOL;
					end else begin
						keep_char(b);
					end
				end
				M_COMMENT: begin
					if (b == CH_NL || b == CH_NUL) begin
						lex_mode = M_IDLE;
						lead_byte(b);
					end
				end
				M_STOPPED: ;
				default: begin
					lex_mode = M_IDLE;
					lead_byte(b);
				end
			endcase
		end
		if (step_words.size() > 0) begin
			step_words[step_words.size() - 1].rlast = 1'b1;
		end
		foreach (step_words[i]) begin
			expected_words.push_back(step_words[i]);
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		token_word_t want;
		if (!arst_n) begin
			reset_lexer();
			expected_words.delete();
		end else begin
			if (text_valid && !text_stall) begin
				predict(text_byte, end_of_text);
			end
			if (token_valid && !token_stall) begin
				if (expected_words.size() == 0) begin
					$error("token word with nothing expected: kind %0d char %0d",
						token_kind, token_char);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("token_kind", want.kind, token_kind);
					check_field("token_char", want.ch, token_char);
					check_field("char_valid", want.cv, char_valid);
					check_field("token_last", want.tlast, token_last);
					check_field("run_last", want.rlast, run_last);
					check_field("symbol_truncated", want.trunc, symbol_truncated);
					check_field("stopped_early", want.stop, stopped_early);
				end
			end
		end
		pending_words = expected_words.size();
	end

endmodule

// File: verif/shell_command_lexer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_lexer_top_tb
// drives shell text into the lexer, first a few hand-made texts for operators,
// keywords, quotes, comments and stops, then random texts built from
// well-formed pieces with some noise, both sides idling at random
// ----------------------------------------------------------------------------
module shell_command_lexer_top_tb;

	import scl_pkg::*;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       text_valid  = 1'b0;
	logic [7:0] text_byte   = 8'h00;
	logic       end_of_text = 1'b0;
	logic       token_stall = 1'b0;
	logic       text_stall;
	logic       token_valid;
	logic [3:0] token_kind;
	logic [7:0] token_char;
	logic       char_valid;
	logic       token_last;
	logic       run_last;
	logic       symbol_truncated;
	logic       stopped_early;
	int         fail_count;
	int         pending_words;

	bit         tx_calm     = 1'b0;
	bit         rx_calm     = 1'b0;
	int         stall_left  = 0;
	int         sent_words  = 0;
	logic [7:0] text_bytes [$];

	string      kw_words [8] = '{"if", "fi", "then", "while", "do", "done", "else", "elif"};
	string      op_words [7] = '{"|", "||", "&", "&&", ";", ">", "\n"};
	string      sym_chars    = "abcxyzAZ09_-./:=$+*";
	logic [7:0] space_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	shell_command_lexer_top DUT (.*);

	shell_command_lexer_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// token side: after each word taken, hold stall for a random count
	always @(posedge clk) begin : rx_side
		int n;
		n = stall_left;
		if (token_valid && !token_stall) begin
			n = rx_calm ? 0 : $urandom_range(0, 7);
		end
		token_stall <= (n > 0);
		stall_left  <= (n > 0) ? n - 1 : 0;
	end

	task automatic send_word(input logic [7:0] b, input logic e);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid  <= 1'b1;
		text_byte   <= b;
		end_of_text <= e;
		do @(posedge clk); while (text_stall);
	endtask

	task automatic send_text();
		foreach (text_bytes[i]) begin
			send_word(text_bytes[i], 1'b0);
		end
		send_word(8'($urandom_range(0, 255)), 1'b1);
		sent_words += text_bytes.size() + 1;
		text_bytes.delete();
	endtask

	task automatic settle();
		text_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
	endtask

	function automatic void add_string(input string s);
		foreach (s[i]) begin
			text_bytes.push_back(s[i]);
		end
	endfunction

	function automatic void add_piece();
		int         pick;
		int         n;
		logic [7:0] q;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			add_string(kw_words[$urandom_range(0, 7)]);
		end else if (pick < 45) begin
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
			repeat (n) text_bytes.push_back(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
		end else if (pick < 55) begin
			case ($urandom_range(0, 2))
				0: q = CH_DQ;
				1: q = CH_SQ;
				default: q = CH_BQ;
			endcase
			text_bytes.push_back(q);
			repeat ($urandom_range(0, 5)) text_bytes.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 7) != 0) begin
				text_bytes.push_back(q);
			end
		end else if (pick < 75) begin
			add_string(op_words[$urandom_range(0, 6)]);
		end else if (pick < 82) begin
			text_bytes.push_back(CH_HASH);
			repeat ($urandom_range(0, 4)) text_bytes.push_back(8'($urandom_range(0, 255)));
			text_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_NUL : CH_NL);
		end else if (pick < 97) begin
			text_bytes.push_back(space_set[$urandom_range(0, 5)]);
		end else begin
			text_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) == 1) begin
			text_bytes.push_back(8'h20);
		end
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keyword into pipe, or, empty symbol, and, amp, semicolon, write,
		// comment open at end of text
		add_string("if|x||\"\" &&a&b;>#q");
		send_text();
		// quote open at end of text
		add_string("'a");
		send_text();
		// zero byte stops, later bytes ignored
		text_bytes.push_back(CH_NUL);
		text_bytes.push_back(8'hFF);
		send_text();
		settle();

		while (sent_words < 210) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm <= ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 8)) add_piece();
			send_text();
			if ($urandom_range(0, 7) == 0) begin
				settle();
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/scl_pkg.sv
rtl/scl_front.sv
rtl/scl_fifo.sv
rtl/scl_back.sv
rtl/shell_command_lexer_top.sv
verif/shell_command_lexer_checker.sv
verif/shell_command_lexer_top_tb.sv
